FILE: hdl/slas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slas_pkg
// Shared types, constants and helpers for the linear approximation scan.
// ----------------------------------------------------------------------------
package slas_pkg;

   // table and mask geometry
   localparam int unsigned TABLE_DEPTH = 64;
   localparam int unsigned ADDR_W      = 6;
   localparam int unsigned VALUE_W     = 4;
   localparam int unsigned COUNT_W     = 7;
   localparam int unsigned GROUP_COUNT = 8;
   localparam int unsigned GROUP_SIZE  = 8;
   localparam int unsigned GROUP_W     = 4;

   localparam logic [ADDR_W-1:0]  MASK_FIRST = 6'd1;
   localparam logic [ADDR_W-1:0]  MASK_LAST  = 6'd63;
   localparam logic [ADDR_W-1:0]  X_LAST     = 6'd63;
   localparam logic [COUNT_W-1:0] COUNT_HALF = 7'd32;
   localparam logic [COUNT_W-1:0] COUNT_FULL = 7'd64;

   // threshold reset values
   localparam logic [COUNT_W-1:0] NOTABLE_HIGH_RESET = 7'd42;
   localparam logic [COUNT_W-1:0] NOTABLE_LOW_RESET  = 7'd22;

   // register indexes of the csr port
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_NOTABLE_HIGH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NOTABLE_LOW  = 2'd1;

   // default queue depths
   localparam int unsigned CMD_DEPTH_DEFAULT = 2;
   localparam int unsigned RSP_DEPTH_DEFAULT = 4;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_SCAN = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_DRAIN,
      ST_SWEEP
   } state_type;

   typedef struct packed {
      opcode_type         op;
      logic [ADDR_W-1:0]  addr;
      logic [VALUE_W-1:0] value;
      logic [VALUE_W-1:0] out_mask;
   } cmd_type;

   typedef struct packed {
      logic [COUNT_W-1:0] notable_high;
      logic [COUNT_W-1:0] notable_low;
   } cfg_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  in_mask;
      logic [COUNT_W-1:0] match_count;
      logic               notable;
      logic               bias_sign;
      logic [COUNT_W-1:0] bias_count;
      logic               last;
   } rsp_type;

   // des row/column remap: bit 5 stays, bit 0 to bit 4, bits 4..1 to 3..0
   function automatic logic [ADDR_W-1:0] remap_input(input logic [ADDR_W-1:0] x);
      remap_input = {x[5], x[0], x[4:1]};
   endfunction

endpackage

`default_nettype wire

FILE: hdl/slas_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slas_front
// Accepts request transactions, classifies them as load or scan commands
// and holds them in a short command queue for the back end.
// ----------------------------------------------------------------------------
module slas_front #(
   parameter int unsigned CMD_DEPTH = slas_pkg::CMD_DEPTH_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_push,
   output logic                              req_full,
   input  wire logic                         req_opcode,
   input  wire logic [slas_pkg::ADDR_W-1:0]  req_entry_addr,
   input  wire logic [slas_pkg::VALUE_W-1:0] req_entry_value,
   input  wire logic [slas_pkg::VALUE_W-1:0] req_out_mask,
   output logic                              cmd_valid,
   output slas_pkg::cmd_type                 cmd,
   input  wire logic                         cmd_pop
);

   localparam int unsigned PW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
   localparam int unsigned CW = $clog2(CMD_DEPTH + 1);

   slas_pkg::cmd_type cmd_mem [CMD_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;
   slas_pkg::cmd_type new_cmd;

   // classify the incoming transaction
   always_comb begin
      new_cmd.op       = req_opcode ? slas_pkg::OP_SCAN : slas_pkg::OP_LOAD;
      new_cmd.addr     = req_entry_addr;
      new_cmd.value    = req_entry_value;
      new_cmd.out_mask = req_out_mask;
   end

   assign req_full  = (count_ff == CW'(CMD_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = cmd_mem[rd_ptr_ff];
   assign do_push   = req_push && !req_full;
   assign do_pop    = cmd_pop && cmd_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // command storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         cmd_mem[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/slas_rsp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slas_rsp_queue
// Result queue between the counting pipeline and the response port.
// ----------------------------------------------------------------------------
module slas_rsp_queue #(
   parameter int unsigned RSP_DEPTH = slas_pkg::RSP_DEPTH_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push,
   input  slas_pkg::rsp_type                 push_data,
   output logic [$clog2(RSP_DEPTH + 1)-1:0]  count,
   output logic                              rsp_empty,
   input  wire logic                         rsp_pop,
   output slas_pkg::rsp_type                 rsp_data
);

   localparam int unsigned PW = (RSP_DEPTH > 1) ? $clog2(RSP_DEPTH) : 1;
   localparam int unsigned CW = $clog2(RSP_DEPTH + 1);

   slas_pkg::rsp_type rsp_mem [RSP_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign count     = count_ff;
   assign rsp_empty = (count_ff == '0);
   assign rsp_data  = rsp_mem[rd_ptr_ff];
   assign do_push   = push && (count_ff != CW'(RSP_DEPTH));
   assign do_pop    = rsp_pop && !rsp_empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(RSP_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(RSP_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // result storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         rsp_mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/slas_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slas_back
// Executes commands: loads write the s-box table, scans read it once to
// build the output parity vector and then sweep all nonzero input masks through a
// two-stage counting pipeline.
// ----------------------------------------------------------------------------
module slas_back #(
   parameter int unsigned RSP_DEPTH = slas_pkg::RSP_DEPTH_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        cmd_valid,
   input  slas_pkg::cmd_type                cmd,
   output logic                             cmd_pop,
   input  slas_pkg::cfg_type                cfg,
   input  wire logic [$clog2(RSP_DEPTH + 1)-1:0] rsp_count,
   output logic                             rsp_push,
   output slas_pkg::rsp_type                rsp_data
);

   localparam int unsigned CW = $clog2(RSP_DEPTH + 1);

   typedef logic [slas_pkg::GROUP_W-1:0] group_count_type;

   // s-box table
   logic [slas_pkg::VALUE_W-1:0] sbox_mem [slas_pkg::TABLE_DEPTH];

   slas_pkg::state_type state_ff, state_in;

   logic [slas_pkg::VALUE_W-1:0] mask_ff, mask_in;
   logic [slas_pkg::ADDR_W-1:0]  x_ff, x_in;
   logic [slas_pkg::ADDR_W-1:0]  m_ff, m_in;

   logic                         rd_vld_ff;
   logic [slas_pkg::ADDR_W-1:0]  rd_x_ff;
   logic [slas_pkg::VALUE_W-1:0] rd_data_ff;

   logic [slas_pkg::TABLE_DEPTH-1:0] outpar_ff, outpar_in;

   logic                        s1_vld_ff;
   logic [slas_pkg::ADDR_W-1:0] s1_m_ff;
   group_count_type             s1_grp_ff [slas_pkg::GROUP_COUNT];
   group_count_type             s1_grp_in [slas_pkg::GROUP_COUNT];

   logic              s2_vld_ff;
   slas_pkg::rsp_type s2_rsp_ff, s2_rsp_in;

   logic          do_load, do_start, do_read, do_issue, fill_done, sweep_done;
   logic [CW:0]   occupancy;
   logic          space;

   // room in the result queue for everything in flight
   assign occupancy = (CW+1)'(rsp_count) + (CW+1)'(s1_vld_ff) + (CW+1)'(s2_vld_ff);
   assign space     = occupancy < (CW+1)'(RSP_DEPTH);

   assign fill_done  = (x_ff == slas_pkg::X_LAST);
   assign sweep_done = (m_ff == slas_pkg::MASK_LAST);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         slas_pkg::ST_IDLE: begin
            if (cmd_valid && cmd.op == slas_pkg::OP_SCAN) begin
               state_in = slas_pkg::ST_FILL;
            end
         end
         slas_pkg::ST_FILL: begin
            if (fill_done) begin
               state_in = slas_pkg::ST_DRAIN;
            end
         end
         slas_pkg::ST_DRAIN: begin
            state_in = slas_pkg::ST_SWEEP;
         end
         slas_pkg::ST_SWEEP: begin
            if (space && sweep_done) begin
               state_in = slas_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = slas_pkg::ST_IDLE;
         end
      endcase
   end

   // control outputs
   always_comb begin
      cmd_pop  = 1'b0;
      do_load  = 1'b0;
      do_start = 1'b0;
      do_read  = 1'b0;
      do_issue = 1'b0;
      case (state_ff)
         slas_pkg::ST_IDLE: begin
            cmd_pop  = cmd_valid;
            do_load  = cmd_valid && cmd.op == slas_pkg::OP_LOAD;
            do_start = cmd_valid && cmd.op == slas_pkg::OP_SCAN;
         end
         slas_pkg::ST_FILL: begin
            do_read = 1'b1;
         end
         slas_pkg::ST_SWEEP: begin
            do_issue = space;
         end
         default: begin
            cmd_pop = 1'b0;
         end
      endcase
   end

   // scan counters and latched output mask
   always_comb begin
      mask_in = mask_ff;
      x_in    = x_ff;
      m_in    = m_ff;
      if (do_start) begin
         mask_in = cmd.out_mask;
         x_in    = '0;
         m_in    = slas_pkg::MASK_FIRST;
      end
      if (do_read) begin
         x_in = x_ff + slas_pkg::ADDR_W'(1);
      end
      if (do_issue) begin
         m_in = m_ff + slas_pkg::ADDR_W'(1);
      end
   end

   // output parity vector, one bit per table read
   always_comb begin
      outpar_in = outpar_ff;
      if (rd_vld_ff) begin
         outpar_in[rd_x_ff] = ^(rd_data_ff & mask_ff);
      end
   end

   // stage 1: agreement vector, counted in groups of eight
   always_comb begin
      logic [slas_pkg::ADDR_W-1:0] xv;
      logic                        agree;
      for (int g = 0; g < int'(slas_pkg::GROUP_COUNT); g++) begin
         s1_grp_in[g] = '0;
         for (int b = 0; b < int'(slas_pkg::GROUP_SIZE); b++) begin
            xv    = slas_pkg::ADDR_W'(g * int'(slas_pkg::GROUP_SIZE) + b);
            agree = ~((^(xv & m_ff)) ^ outpar_ff[xv]);
            s1_grp_in[g] = s1_grp_in[g] + slas_pkg::GROUP_W'(agree);
         end
      end
   end

   // stage 2: total count, thresholds and bias
   always_comb begin
      logic [slas_pkg::COUNT_W-1:0] n;
      n = '0;
      for (int g = 0; g < int'(slas_pkg::GROUP_COUNT); g++) begin
         n = n + slas_pkg::COUNT_W'(s1_grp_ff[g]);
      end
      s2_rsp_in.in_mask     = s1_m_ff;
      s2_rsp_in.match_count = n;
      s2_rsp_in.notable     = (n > cfg.notable_high) || (n < cfg.notable_low);
      s2_rsp_in.bias_sign   = !(n > slas_pkg::COUNT_HALF);
      s2_rsp_in.bias_count  = (n > slas_pkg::COUNT_HALF) ? n : (slas_pkg::COUNT_FULL - n);
      s2_rsp_in.last        = (s1_m_ff == slas_pkg::MASK_LAST);
   end

   assign rsp_push = s2_vld_ff;
   assign rsp_data = s2_rsp_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= slas_pkg::ST_IDLE;
         rd_vld_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= do_read;
         s1_vld_ff <= do_issue;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      mask_ff   <= mask_in;
      x_ff      <= x_in;
      m_ff      <= m_in;
      rd_x_ff   <= x_ff;
      outpar_ff <= outpar_in;
      if (do_issue) begin
         s1_m_ff   <= m_ff;
         s1_grp_ff <= s1_grp_in;
      end
      if (s1_vld_ff) begin
         s2_rsp_ff <= s2_rsp_in;
      end
   end

   // table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (do_load) begin
         sbox_mem[cmd.addr] <= cmd.value;
      end
      if (do_read) begin
         rd_data_ff <= sbox_mem[slas_pkg::remap_input(x_ff)];
      end
   end

   // checks
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      s2_vld_ff |-> (rsp_count < CW'(RSP_DEPTH)))
      else $error("result pushed into a full queue");

   a_sweep_after_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == slas_pkg::ST_SWEEP) |-> !rd_vld_ff)
      else $error("parity vector still filling during sweep");

   a_last_mask: assert property (@(posedge clock) disable iff (reset)
      (s2_vld_ff && s2_rsp_ff.last) |-> (s2_rsp_ff.in_mask == slas_pkg::MASK_LAST))
      else $error("last flag on wrong input mask");

   a_fill_to_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == slas_pkg::ST_FILL && fill_done) |=> (state_ff == slas_pkg::ST_DRAIN))
      else $error("fill did not end in drain");

endmodule

`default_nettype wire

FILE: hdl/sbox_linear_approximation_scan.sv
// a load is queued, then written to the table when the idle back end pops it.
// a scan reads the table once (single memory read port), then issues one input mask per cycle
// while the result queue has room; no new command is taken until its sweep ends.
// loads one per cycle while the back end is idle, results at most one per cycle.
// reset: clears queues, sequencer and thresholds (42 and 22); the table is not cleared.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbox_linear_approximation_scan
// One row of the linear approximation table of a 6-to-4-bit des s-box.
// ----------------------------------------------------------------------------
module sbox_linear_approximation_scan #(
   parameter int unsigned CMD_DEPTH = slas_pkg::CMD_DEPTH_DEFAULT,
   parameter int unsigned RSP_DEPTH = slas_pkg::RSP_DEPTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_push,
   output logic                                  req_full,
   input  wire logic                             req_opcode,
   input  wire logic [slas_pkg::ADDR_W-1:0]      req_entry_addr,
   input  wire logic [slas_pkg::VALUE_W-1:0]     req_entry_value,
   input  wire logic [slas_pkg::VALUE_W-1:0]     req_out_mask,
   // response channel
   output logic                                  rsp_empty,
   input  wire logic                             rsp_pop,
   output logic [slas_pkg::ADDR_W-1:0]           rsp_in_mask,
   output logic [slas_pkg::COUNT_W-1:0]          rsp_match_count,
   output logic                                  rsp_notable,
   output logic                                  rsp_bias_sign,
   output logic [slas_pkg::COUNT_W-1:0]          rsp_bias_count,
   output logic                                  rsp_last,
   // csr write channel
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [slas_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [slas_pkg::COUNT_W-1:0]     csr_data
);

   slas_pkg::cmd_type cmd;
   logic              cmd_valid, cmd_pop;
   slas_pkg::cfg_type cfg_ff, cfg_in;
   logic              rsp_push;
   slas_pkg::rsp_type push_data, rsp_data;
   logic [$clog2(RSP_DEPTH + 1)-1:0] rsp_count;

   // threshold registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            slas_pkg::CSR_NOTABLE_HIGH: cfg_in.notable_high = csr_data;
            slas_pkg::CSR_NOTABLE_LOW:  cfg_in.notable_low  = csr_data;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.notable_high <= slas_pkg::NOTABLE_HIGH_RESET;
         cfg_ff.notable_low  <= slas_pkg::NOTABLE_LOW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end and command queue
   slas_front #(
      .CMD_DEPTH (CMD_DEPTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_opcode      (req_opcode),
      .req_entry_addr  (req_entry_addr),
      .req_entry_value (req_entry_value),
      .req_out_mask    (req_out_mask),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop)
   );

   // back end
   slas_back #(
      .RSP_DEPTH (RSP_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .cfg       (cfg_ff),
      .rsp_count (rsp_count),
      .rsp_push  (rsp_push),
      .rsp_data  (push_data)
   );

   // result queue
   slas_rsp_queue #(
      .RSP_DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (push_data),
      .count     (rsp_count),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   assign rsp_in_mask     = rsp_data.in_mask;
   assign rsp_match_count = rsp_data.match_count;
   assign rsp_notable     = rsp_data.notable;
   assign rsp_bias_sign   = rsp_data.bias_sign;
   assign rsp_bias_count  = rsp_data.bias_count;
   assign rsp_last        = rsp_data.last;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the linear approximation scan of a 6-to-4-bit s-box. A shadow copy
// of the table and thresholds predicts all 63 rows of each scan; every popped
// row is compared field by field against the oldest predicted row. Directed
// tables force counts of 0, 32 and 64, then random loads and scans run with
// bursty requests, a stalling receiver and threshold changes between phases.
// ----------------------------------------------------------------------------
module testbench;

   typedef enum int unsigned {
      POP_ALWAYS,
      POP_RANDOM,
      POP_EVERY_THIRD,
      POP_LONG_STALL
   } pop_mode_type;

   // des s1 in file layout, row-major, first entry in the top nibble
   localparam logic [255:0] DES_S1 = {
      64'hE4D12FB83A6C5907, 64'h0F74E2D1A6CB9538,
      64'h41E8D62BFC973A50, 64'hFC8249175B3EA06D
   };
   localparam int unsigned LOAD_SETTLE = 8;
   localparam int unsigned END_SETTLE  = 200;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_push = 1'b0;
   logic                             req_full;
   logic                             req_opcode = slas_pkg::OP_LOAD;
   logic [slas_pkg::ADDR_W-1:0]      req_entry_addr = '0;
   logic [slas_pkg::VALUE_W-1:0]     req_entry_value = '0;
   logic [slas_pkg::VALUE_W-1:0]     req_out_mask = '0;
   logic                             rsp_empty;
   logic                             rsp_pop = 1'b0;
   logic [slas_pkg::ADDR_W-1:0]      rsp_in_mask;
   logic [slas_pkg::COUNT_W-1:0]     rsp_match_count;
   logic                             rsp_notable;
   logic                             rsp_bias_sign;
   logic [slas_pkg::COUNT_W-1:0]     rsp_bias_count;
   logic                             rsp_last;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [slas_pkg::CSR_INDEX_W-1:0] csr_index = slas_pkg::CSR_NOTABLE_HIGH;
   logic [slas_pkg::COUNT_W-1:0]     csr_data = '0;

   // shadow state of the block
   logic [slas_pkg::VALUE_W-1:0] sbox_shadow [slas_pkg::TABLE_DEPTH];
   logic [slas_pkg::COUNT_W-1:0] thr_high = slas_pkg::NOTABLE_HIGH_RESET;
   logic [slas_pkg::COUNT_W-1:0] thr_low  = slas_pkg::NOTABLE_LOW_RESET;
   slas_pkg::rsp_type            pending_rows [$];
   int unsigned                  mismatches = 0;
   int unsigned                  burst_left = 0;

   sbox_linear_approximation_scan dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_opcode      (req_opcode),
      .req_entry_addr  (req_entry_addr),
      .req_entry_value (req_entry_value),
      .req_out_mask    (req_out_mask),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_in_mask     (rsp_in_mask),
      .rsp_match_count (rsp_match_count),
      .rsp_notable     (rsp_notable),
      .rsp_bias_sign   (rsp_bias_sign),
      .rsp_bias_count  (rsp_bias_count),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatches < 40) begin
         $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      end
      mismatches++;
   endtask

   // expected rows of one scan: parity counts over all 63 input masks
   function automatic void predict_scan_rows(input logic [slas_pkg::VALUE_W-1:0] omask);
      logic [slas_pkg::TABLE_DEPTH-1:0] out_parity;
      logic [slas_pkg::ADDR_W-1:0]      x6;
      logic [slas_pkg::ADDR_W-1:0]      m6;
      logic [slas_pkg::COUNT_W-1:0]     n;
      slas_pkg::rsp_type                row;
      int                               x;
      int                               m;
      for (x = 0; x < slas_pkg::TABLE_DEPTH; x++) begin
         x6 = slas_pkg::ADDR_W'(x);
         // row from the outer bits, column from the middle four
         out_parity[x] = ^(sbox_shadow[{x6[5], x6[0], x6[4:1]}] & omask);
      end
      for (m = 1; m < slas_pkg::TABLE_DEPTH; m++) begin
         m6 = slas_pkg::ADDR_W'(m);
         n = '0;
         for (x = 0; x < slas_pkg::TABLE_DEPTH; x++) begin
            x6 = slas_pkg::ADDR_W'(x);
            if ((^(x6 & m6)) == out_parity[x]) n++;
         end
         row.in_mask     = m6;
         row.match_count = n;
         row.notable     = (n > thr_high) || (n < thr_low);
         row.bias_sign   = (n <= slas_pkg::COUNT_HALF);
         row.bias_count  = row.bias_sign ? slas_pkg::COUNT_FULL - n : n;
         row.last        = (m6 == slas_pkg::MASK_LAST);
         pending_rows.push_back(row);
      end
   endfunction

   // one request transaction, with random gaps between bursts
   task automatic send_item(input slas_pkg::opcode_type op,
                            input logic [slas_pkg::ADDR_W-1:0] addr,
                            input logic [slas_pkg::VALUE_W-1:0] value,
                            input logic [slas_pkg::VALUE_W-1:0] omask);
      if (burst_left == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 10);
      end
      burst_left--;
      req_push        <= 1'b1;
      req_opcode      <= op;
      req_entry_addr  <= addr;
      req_entry_value <= value;
      req_out_mask    <= omask;
      do @(posedge clock); while (req_full);
      if (op == slas_pkg::OP_LOAD) begin
         sbox_shadow[addr] = value;
      end else begin
         predict_scan_rows(omask);
      end
   endtask

   // stop requests and let every row and pending table write finish
   task automatic wait_idle();
      req_push <= 1'b0;
      while (pending_rows.size() != 0) @(posedge clock);
      repeat (LOAD_SETTLE) @(posedge clock);
   endtask

   task automatic set_thresholds(input logic [slas_pkg::COUNT_W-1:0] hi,
                                 input logic [slas_pkg::COUNT_W-1:0] lo);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= slas_pkg::CSR_NOTABLE_HIGH;
      csr_data  <= hi;
      do @(posedge clock); while (!csr_ready);
      csr_index <= slas_pkg::CSR_NOTABLE_LOW;
      csr_data  <= lo;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      thr_high = hi;
      thr_low  = lo;
   endtask

   task automatic load_des_s1();
      int a;
      for (a = 0; a < slas_pkg::TABLE_DEPTH; a++) begin
         send_item(slas_pkg::OP_LOAD, slas_pkg::ADDR_W'(a), DES_S1[255 - 4 * a -: 4],
                   4'($urandom));
      end
   endtask

   // table whose parities follow input bit 0: counts of 64, 0 and 32
   task automatic test_linear_extremes();
      logic [slas_pkg::ADDR_W-1:0] a6;
      int                          a;
      for (a = 0; a < slas_pkg::TABLE_DEPTH; a++) begin
         a6 = slas_pkg::ADDR_W'(a);
         send_item(slas_pkg::OP_LOAD, a6, {a6[4], 2'b00, ~a6[4]}, 4'($urandom));
      end
      send_item(slas_pkg::OP_SCAN, 6'($urandom), 4'($urandom), 4'd8);
      send_item(slas_pkg::OP_SCAN, 6'($urandom), 4'($urandom), 4'd1);
      send_item(slas_pkg::OP_SCAN, 6'($urandom), 4'($urandom), 4'd9);
      // zero output mask
      send_item(slas_pkg::OP_SCAN, 6'($urandom), 4'($urandom), 4'd0);
   endtask

   task automatic test_des_s1();
      load_des_s1();
      send_item(slas_pkg::OP_SCAN, 6'($urandom), 4'($urandom), 4'd15);
      send_item(slas_pkg::OP_SCAN, 6'($urandom), 4'($urandom), 4'd4);
   endtask

   // threshold extremes, both registers each time
   task automatic test_threshold_extremes();
      set_thresholds(7'd0, 7'd0);
      send_item(slas_pkg::OP_SCAN, 6'($urandom), 4'($urandom), 4'd15);
      set_thresholds(7'd64, 7'd64);
      send_item(slas_pkg::OP_SCAN, 6'($urandom), 4'($urandom), 4'd1);
      set_thresholds(7'd127, 7'd0);
      send_item(slas_pkg::OP_SCAN, 6'($urandom), 4'($urandom), 4'd10);
      set_thresholds(7'd0, 7'd127);
      send_item(slas_pkg::OP_SCAN, 6'($urandom), 4'($urandom), 4'd7);
      set_thresholds(7'd127, 7'd127);
      send_item(slas_pkg::OP_SCAN, 6'($urandom), 4'($urandom), 4'd0);
      set_thresholds(7'd32, 7'd33);
      send_item(slas_pkg::OP_SCAN, 6'($urandom), 4'($urandom), 4'd15);
      set_thresholds(slas_pkg::NOTABLE_HIGH_RESET, slas_pkg::NOTABLE_LOW_RESET);
   endtask

   // loads queued right behind scans must land in order
   task automatic test_load_between_scans();
      burst_left = 16;
      send_item(slas_pkg::OP_SCAN, 6'd63, 4'd15, 4'd15);
      send_item(slas_pkg::OP_LOAD, 6'd0, 4'd15, 4'd0);
      send_item(slas_pkg::OP_SCAN, 6'd0, 4'd0, 4'd15);
      send_item(slas_pkg::OP_LOAD, 6'd63, 4'd0, 4'd15);
      send_item(slas_pkg::OP_LOAD, 6'd32, 4'd9, 4'd6);
      send_item(slas_pkg::OP_SCAN, 6'd21, 4'd6, 4'd6);
   endtask

   task automatic test_random_traffic();
      int i;
      for (i = 0; i < 12; i++) begin
         if (i == 4 || i == 8) begin
            set_thresholds(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
         end
         if ($urandom_range(0, 3) == 0) begin
            send_item(slas_pkg::OP_SCAN, 6'($urandom), 4'($urandom),
                      4'($urandom_range(0, 15)));
         end else begin
            send_item(slas_pkg::OP_LOAD, 6'($urandom), 4'($urandom), 4'($urandom));
         end
      end
   endtask

   // result checker and receiver stall pattern
   initial begin : row_checker
      slas_pkg::rsp_type want;
      pop_mode_type      mode;
      int unsigned       mode_left;
      int unsigned       stall_left;
      int unsigned       beat;
      logic              pop_next;
      mode       = POP_ALWAYS;
      mode_left  = 0;
      stall_left = 0;
      beat       = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            if (pending_rows.size() == 0) begin
               report_mismatch("unexpected row, in_mask", rsp_in_mask, 0);
            end else begin
               want = pending_rows.pop_front();
               if (rsp_in_mask != want.in_mask)
                  report_mismatch("in_mask", rsp_in_mask, want.in_mask);
               if (rsp_match_count != want.match_count)
                  report_mismatch($sformatf("mask %0d match_count", want.in_mask),
                                  rsp_match_count, want.match_count);
               if (rsp_notable != want.notable)
                  report_mismatch($sformatf("mask %0d notable", want.in_mask),
                                  rsp_notable, want.notable);
               if (rsp_bias_sign != want.bias_sign)
                  report_mismatch($sformatf("mask %0d bias_sign", want.in_mask),
                                  rsp_bias_sign, want.bias_sign);
               if (rsp_bias_count != want.bias_count)
                  report_mismatch($sformatf("mask %0d bias_count", want.in_mask),
                                  rsp_bias_count, want.bias_count);
               if (rsp_last != want.last)
                  report_mismatch($sformatf("mask %0d last", want.in_mask),
                                  rsp_last, want.last);
            end
         end
         // pick the pop for the next edge
         if (mode_left == 0) begin
            mode      = pop_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(50, 300);
         end
         mode_left--;
         case (mode)
            POP_ALWAYS: pop_next = 1'b1;
            POP_RANDOM: pop_next = 1'($urandom_range(0, 1));
            POP_EVERY_THIRD: begin
               beat++;
               pop_next = (beat % 3 == 0);
            end
            default: begin
               if (stall_left == 0) begin
                  pop_next   = 1'b1;
                  stall_left = $urandom_range(4, 20);
               end else begin
                  pop_next = 1'b0;
                  stall_left--;
               end
            end
         endcase
         rsp_pop <= reset ? 1'b0 : pop_next;
      end
   end

   // test sequence
   initial begin : main_sequence
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_linear_extremes();
      test_des_s1();
      test_threshold_extremes();
      test_load_between_scans();
      test_random_traffic();
      wait_idle();
      repeat (END_SETTLE) @(posedge clock);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/slas_pkg.sv
hdl/slas_front.sv
hdl/slas_rsp_queue.sv
hdl/slas_back.sv
hdl/sbox_linear_approximation_scan.sv
tb/testbench.sv
